@@ hw/rtl/csv_field_parser_assert.svh @@
// assertion macros for the csv field parser
// used by the top level; no other dependencies
`ifndef CSV_FIELD_PARSER_ASSERT_SVH
`define CSV_FIELD_PARSER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CSVFP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("csv field parser check failed");

// next-cycle implication, checked out of reset
`define CSVFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("csv field parser check failed");

`endif

@@ hw/rtl/csvfp_pkg.sv @@
// shared types and constants of the csv field parser
// no dependencies
package csvfp_pkg;

   localparam int unsigned MAX_FIELDS  = 256;
   localparam int unsigned IDX_CAP_INT = ((MAX_FIELDS - 1) < 255) ? (MAX_FIELDS - 1) : 255;
   localparam logic [7:0]  IDX_CAP     = 8'(IDX_CAP_INT);

   localparam int unsigned NUM_SEPS   = 4;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SEP_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SEP_0     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SEP_1     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SEP_2     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SEP_3     = 3'd4;

   localparam logic [2:0] SEP_COUNT_RESET = 3'd1;
   localparam logic [7:0] SEP_RESET       = 8'd44;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_LF    = 8'h0a;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       field_end;
      logic       line_end;
      logic [7:0] field_index;
   } rsp_payload_type;

   typedef struct packed {
      logic            emit;
      rsp_payload_type rsp;
   } step_result_type;

   typedef enum logic [5:0] {
      PH_LINE   = 6'b000001,
      PH_FSTART = 6'b000010,
      PH_PLAIN  = 6'b000100,
      PH_QUOTED = 6'b001000,
      PH_QSEEN  = 6'b010000,
      PH_TAIL   = 6'b100000
   } phase_type;

endpackage

@@ hw/rtl/csvfp_if.sv @@
// request and response channel interfaces of the csv field parser
// depends on csvfp_pkg
interface csvfp_req_if import csvfp_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface csvfp_rsp_if import csvfp_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/csvfp_sep_unit.sv @@
// separator registers and byte match against the active separators
// depends on csvfp_pkg
module csvfp_sep_unit import csvfp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [7:0]            test_byte,
   output logic                  is_sep
);

   logic [2:0] sep_count_ff;
   logic [7:0] sep_byte_ff [NUM_SEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_count_ff <= SEP_COUNT_RESET;
         for (int i = 0; i < NUM_SEPS; i++) sep_byte_ff[i] <= SEP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_SEP_COUNT: sep_count_ff   <= csr_wdata[2:0];
            REG_SEP_0:     sep_byte_ff[0] <= csr_wdata;
            REG_SEP_1:     sep_byte_ff[1] <= csr_wdata;
            REG_SEP_2:     sep_byte_ff[2] <= csr_wdata;
            REG_SEP_3:     sep_byte_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // count above four leaves all four active
   always_comb begin
      is_sep = 1'b0;
      for (int i = 0; i < NUM_SEPS; i++) begin
         if ((3'(i) < sep_count_ff) && (sep_byte_ff[i] == test_byte)) is_sep = 1'b1;
      end
   end

endmodule

@@ hw/rtl/csvfp_parse_fsm.sv @@
// parse phase, cr memory and field counter with the per-byte step logic
// depends on csvfp_pkg
module csvfp_parse_fsm import csvfp_pkg::*; #(
   parameter int unsigned FIELD_LIMIT = MAX_FIELDS
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  req_payload_type item,
   input  logic            is_sep,
   output step_result_type result
);

   // field index cap, never above what eight bits can show
   localparam logic [7:0] FIELD_CAP = 8'(((FIELD_LIMIT - 1) < 255) ? (FIELD_LIMIT - 1) : 255);

   phase_type  phase_ff,    phase_in;
   logic       after_cr_ff, after_cr_in;
   logic [7:0] count_ff,    count_in;

   logic [7:0] c;
   logic       do_line_end, do_field_end, do_byte;

   assign c = item.in_byte;

   always_comb begin
      phase_in     = phase_ff;
      after_cr_in  = 1'b0;
      count_in     = count_ff;
      do_line_end  = 1'b0;
      do_field_end = 1'b0;
      do_byte      = 1'b0;

      if (item.end_of_input) begin
         do_line_end = (phase_ff != PH_LINE);
      end else if (after_cr_ff && (c == CH_LF)) begin
         // lf of a cr-lf pair: swallowed
      end else if ((c == CH_CR) || (c == CH_LF)) begin
         after_cr_in = (c == CH_CR);
         do_line_end = 1'b1;
      end else begin
         case (phase_ff)
            PH_PLAIN, PH_TAIL: begin
               if (is_sep) do_field_end = 1'b1;
               else do_byte = 1'b1;
            end
            PH_QUOTED: begin
               if (c == CH_QUOTE) phase_in = PH_QSEEN;
               else do_byte = 1'b1;
            end
            PH_QSEEN: begin
               if (c == CH_QUOTE) begin
                  phase_in = PH_QUOTED;
                  do_byte  = 1'b1;
               end else if (is_sep) begin
                  do_field_end = 1'b1;
               end else begin
                  phase_in = PH_TAIL;
                  do_byte  = 1'b1;
               end
            end
            default: begin
               if (c == CH_QUOTE) begin
                  phase_in = PH_QUOTED;
               end else if (is_sep) begin
                  do_field_end = 1'b1;
               end else begin
                  phase_in = PH_PLAIN;
                  do_byte  = 1'b1;
               end
            end
         endcase
      end

      result             = '0;
      result.rsp.field_index = count_ff;
      if (do_line_end) begin
         result.emit         = 1'b1;
         result.rsp.line_end = 1'b1;
         if (phase_ff != PH_LINE) result.rsp.field_end = 1'b1;
         else result.rsp.field_index = '0;
         phase_in = PH_LINE;
         count_in = '0;
      end else if (do_field_end) begin
         result.emit          = 1'b1;
         result.rsp.field_end = 1'b1;
         phase_in             = PH_FSTART;
         if (count_ff < FIELD_CAP) count_in = count_ff + 8'd1;
      end else if (do_byte) begin
         result.emit           = 1'b1;
         result.rsp.byte_valid = 1'b1;
         result.rsp.out_byte   = c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_LINE;
         after_cr_ff <= 1'b0;
         count_ff    <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         after_cr_ff <= after_cr_in;
         count_ff    <= count_in;
      end
   end

endmodule

@@ hw/rtl/csv_field_parser.sv @@
// top level of the csv field parser: input register, parse step, result register
// depends on csvfp_pkg, csvfp_if, csvfp_sep_unit, csvfp_parse_fsm, csv_field_parser_assert.svh
//
// Splits a byte stream into lines and fields, one request byte per clock while the response
// side is ready. A request lands in an input register; from there the parse logic (separator
// match, phase update, field counter) writes at most one result into the output register.
// The input register is free again whenever its byte moves on, so with the response side
// ready the block sustains one request per cycle; a stalled response holds one result and
// one pending request before req ready drops. A byte's result passes from the input
// register to the result register before response valid rises, waiting in the input
// register while the result register is held. Bytes that give no result (opening and
// closing quotes, the lf of a cr-lf pair, end of stream at line start) are consumed with
// no response. The field index saturates at FIELD_LIMIT - 1, never above 255. The user
// must write separators through the csr port only while idle; the block does not enforce it.
module csv_field_parser import csvfp_pkg::*; #(
   parameter int unsigned FIELD_LIMIT = MAX_FIELDS
) (
   input  logic                  clock,
   input  logic                  reset,
   csvfp_req_if.sink             req_chan,
   csvfp_rsp_if.source           rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // input register
   req_payload_type item_ff, item_in;
   logic            item_valid_ff, item_valid_in;

   // result register
   rsp_payload_type rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;

   logic            accept;
   logic            advance;
   logic            is_sep;
   step_result_type result;

   // the held byte moves on when the result register is empty or being drained
   assign advance = item_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !item_valid_ff || advance;
   assign accept  = req_chan.valid && req_chan.ready;

   csvfp_sep_unit u_sep (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .test_byte (item_ff.in_byte),
      .is_sep    (is_sep)
   );

   csvfp_parse_fsm #(.FIELD_LIMIT(FIELD_LIMIT)) u_fsm (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item_ff),
      .is_sep (is_sep),
      .result (result)
   );

   always_comb begin
      item_in       = accept ? req_chan.payload : item_ff;
      item_valid_in = accept ? 1'b1 : (advance ? 1'b0 : item_valid_ff);

      // advance implies the old result is gone or taken this cycle
      rsp_in       = (advance && result.emit) ? result.rsp : rsp_ff;
      rsp_valid_in = advance ? result.emit : (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers carry no reset
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   // checks
   `include "csv_field_parser_assert.svh"

   // a content byte never carries a mark
   `CSVFP_ASSERT_NOW(a_byte_no_mark, clock, reset,
      rsp_valid_ff && rsp_ff.byte_valid, !rsp_ff.field_end && !rsp_ff.line_end && !1'b0)
   // a result without a byte is a mark, with a zero byte
   `CSVFP_ASSERT_NOW(a_mark_only, clock, reset,
      rsp_valid_ff && !rsp_ff.byte_valid,
      (rsp_ff.field_end || rsp_ff.line_end) && (rsp_ff.out_byte == 8'd0))
   // an empty line mark always reports field zero
   `CSVFP_ASSERT_NOW(a_empty_line_idx, clock, reset,
      rsp_valid_ff && rsp_ff.line_end && !rsp_ff.field_end, rsp_ff.field_index == 8'd0)
   // a held byte that cannot move on stays unchanged in the input register
   `CSVFP_ASSERT_NEXT(a_item_held, clock, reset,
      item_valid_ff && !advance, item_valid_ff && $stable(item_ff))

endmodule
